[design/c8ie_pkg.sv]
// shared types, constants and helpers for the chip-8 execute core
`default_nettype none
package c8ie_pkg;

  localparam int unsigned MemDepth   = 4096;
  localparam int unsigned StackDepth = 16;
  localparam int unsigned KeyCount   = 16;

  localparam logic [11:0] PcReset = 12'h200;
  localparam logic [3:0]  FlagReg = 4'hF;

  typedef enum logic [4:0] {
    OP_CLS  = 5'd0,  OP_RET  = 5'd1,  OP_JMP  = 5'd2,  OP_CALL = 5'd3,
    OP_SEQ  = 5'd4,  OP_SNE  = 5'd5,  OP_SCEQ = 5'd6,  OP_LD   = 5'd7,
    OP_ADD  = 5'd8,  OP_CP   = 5'd9,  OP_OR   = 5'd10, OP_AND  = 5'd11,
    OP_XOR  = 5'd12, OP_ADDC = 5'd13, OP_SUB  = 5'd14, OP_SHR  = 5'd15,
    OP_SUBI = 5'd16, OP_SHL  = 5'd17, OP_SCNE = 5'd18, OP_LDI  = 5'd19,
    OP_JMPO = 5'd20, OP_RND  = 5'd21, OP_SAVE = 5'd22, OP_LOAD = 5'd23,
    OP_BCD  = 5'd24, OP_SKP  = 5'd25, OP_SKNP = 5'd26, OP_WKP  = 5'd27,
    OP_ADDI = 5'd28, OP_SETT = 5'd29, OP_GETT = 5'd30, OP_NOP  = 5'd31
  } opcode_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESS   = 2'd1,
    PH_RELEASE = 2'd2,
    PH_UNUSED  = 2'd3
  } wait_phase_e;

  typedef struct packed {
    logic [4:0]  opcode;
    logic [3:0]  reg_x;
    logic [3:0]  reg_y;
    logic [7:0]  imm_byte;
    logic [11:0] imm_addr;
    logic [15:0] keys_down;
    logic [7:0]  random_byte;
    logic [7:0]  timer_now;
  } in_item_t;

  typedef struct packed {
    logic [11:0] next_pc;
    logic        clear_screen;
    logic        timer_write;
    logic [7:0]  timer_value;
    logic        stack_fault;
    logic        key_waiting;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic       load_item;  // capture item, snapshot operands
    logic       exec;       // single-cycle register / pc update
    logic       mem_wr;     // write one byte of save / bcd
    logic       mem_rd;     // issue one read of load
    logic       rd_wb;      // write back read data of load
    logic [3:0] step;       // byte offset within save / load / bcd
    logic       bcd_start;  // begin digit extraction
    logic       bcd_shift;  // one shift-add-3 step
    logic       mem_clr;    // zero one memory word and advance
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic [4:0] opcode;
    logic [3:0] reg_x;
    logic       clr_last;   // clearing pass is at the last word
  } stat_t;

  // double-dabble correction for one bcd digit
  function automatic logic [3:0] dd_adj(input logic [3:0] d);
    dd_adj = (d >= 4'd5) ? 4'(d + 4'd3) : d;
  endfunction

endpackage
`default_nettype wire

[design/chip8_instruction_execute_core.sv]
// top level of the chip-8 instruction execute core
// a new item is accepted only in idle, once the previous result has been taken
// the single data memory port moves one byte a cycle, which paces save, load and bcd
// reset: v registers, i and stack depth clear, pc goes to 0x200, key wait idles
// a clearing pass zeroes all 4096 words of data memory after reset before the first item
`default_nettype none
module chip8_instruction_execute_core #(
  parameter int unsigned StackDepth = c8ie_pkg::StackDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire c8ie_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output c8ie_pkg::out_item_t      out_item_o
);
  // command and status between sequencer and datapath
  c8ie_pkg::ctrl_t ctrl;
  c8ie_pkg::stat_t stat;

  // sequencer: memory clearing, dispatch, byte loops for memory moves, result handshake
  c8ie_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // datapath: registers, stack, data memory, result register
  c8ie_dp #(
    .StackDepth (StackDepth)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .out_item_o (out_item_o)
  );

`ifndef SYNTHESIS
  // no new item while a result is still pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("item accepted with result pending");
  // a result appears only after an accepted item
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_ready_o) else $error("result without item");
  // memory write and read never issued together
  a_mem_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.mem_wr && ctrl.mem_rd)) else $error("memory port conflict");
`endif
endmodule
`default_nettype wire

[design/c8ie_ram.sv]
// generic single-port ram with registered read
`default_nettype none
module c8ie_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

[design/c8ie_ctrl.sv]
// sequencer for the chip-8 execute core
`default_nettype none
module c8ie_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire c8ie_pkg::stat_t stat_i,
  output c8ie_pkg::ctrl_t     ctrl_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_SAVE, S_LOAD, S_BCD_CONV, S_BCD_WR, S_DONE, S_CLEAR
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] step_q, step_d;
  logic       rd_pend_q, rd_pend_d;
  logic       out_valid_q, out_valid_d;

  // an item may enter once the previous result has been taken
  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    rd_pend_d   = 1'b0;
    out_valid_d = out_valid_q;
    ctrl_o      = '0;
    ctrl_o.step = step_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_CLEAR: begin
        ctrl_o.mem_clr = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          ctrl_o.load_item = 1'b1;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        step_d = '0;
        case (stat_i.opcode)
          c8ie_pkg::OP_SAVE: state_d = S_SAVE;
          c8ie_pkg::OP_LOAD: state_d = S_LOAD;
          c8ie_pkg::OP_BCD: begin
            ctrl_o.bcd_start = 1'b1;
            state_d = S_BCD_CONV;
          end
          default: begin
            ctrl_o.exec = 1'b1;
            state_d = S_DONE;
          end
        endcase
      end
      S_SAVE: begin
        ctrl_o.mem_wr = 1'b1;
        step_d = 4'(step_q + 4'd1);
        if (step_q == stat_i.reg_x) begin
          ctrl_o.exec = 1'b1;
          state_d = S_DONE;
        end
      end
      S_LOAD: begin
        // read issued for step, written back in the cycle after
        ctrl_o.rd_wb = rd_pend_q;
        if (!rd_pend_q || step_q != stat_i.reg_x) begin
          if (rd_pend_q) step_d = 4'(step_q + 4'd1);
          ctrl_o.mem_rd = 1'b1;
          ctrl_o.step   = rd_pend_q ? 4'(step_q + 4'd1) : step_q;
          rd_pend_d     = 1'b1;
        end
        if (rd_pend_q && step_q == stat_i.reg_x) begin
          ctrl_o.step = step_q;
          ctrl_o.exec = 1'b1;
          state_d = S_DONE;
        end
      end
      S_BCD_CONV: begin
        ctrl_o.bcd_shift = 1'b1;
        step_d = 4'(step_q + 4'd1);
        if (step_q == 4'd7) begin
          step_d  = '0;
          state_d = S_BCD_WR;
        end
      end
      S_BCD_WR: begin
        ctrl_o.mem_wr = 1'b1;
        step_d = 4'(step_q + 4'd1);
        if (step_q == 4'd2) begin
          ctrl_o.exec = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        out_valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      step_q      <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule
`default_nettype wire

[design/c8ie_dp.sv]
// architectural state and execution datapath of the chip-8 execute core
`default_nettype none
module c8ie_dp #(
  parameter int unsigned StackDepth = c8ie_pkg::StackDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire c8ie_pkg::in_item_t in_item_i,
  input  wire c8ie_pkg::ctrl_t    ctrl_i,
  output c8ie_pkg::stat_t         stat_o,
  output c8ie_pkg::out_item_t     out_item_o
);
  localparam int unsigned MemDepth = c8ie_pkg::MemDepth;
  localparam int unsigned AW = $clog2(MemDepth);
  localparam int unsigned SW = $clog2(StackDepth);
  localparam int unsigned DW = $clog2(StackDepth + 1);

  c8ie_pkg::in_item_t  item_q;
  c8ie_pkg::out_item_t res_q, res_d;
  logic [7:0]  vregs_q [16];
  logic [11:0] pc_q;
  logic [15:0] idx_q;
  logic [DW-1:0] depth_q;
  logic [1:0]  phase_q;
  logic [3:0]  held_q;
  logic [7:0]  vx_q, vy_q;
  logic [19:0] bcd_q;
  logic [3:0]  rd_step_q;
  logic [AW-1:0] clr_q;

  logic [11:0] stk_q [StackDepth];
  logic [11:0] stk_top;

  assign stat_o.opcode   = item_q.opcode;
  assign stat_o.reg_x    = item_q.reg_x;
  assign stat_o.clr_last = (clr_q == AW'(MemDepth - 1));
  assign out_item_o      = res_q;

  // data memory port
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata, mem_rdata;
  logic [15:0]   addr_full;

  assign addr_full = 16'(idx_q + 16'(ctrl_i.step));
  assign mem_addr  = ctrl_i.mem_clr ? clr_q : addr_full[AW-1:0];
  assign mem_we    = ctrl_i.mem_wr || ctrl_i.mem_clr;
  always_comb begin
    if (ctrl_i.mem_clr) begin
      mem_wdata = '0;
    end else if (item_q.opcode == c8ie_pkg::OP_BCD) begin
      case (ctrl_i.step)
        4'd0:    mem_wdata = {4'd0, bcd_q[19:16]};
        4'd1:    mem_wdata = {4'd0, bcd_q[15:12]};
        default: mem_wdata = {4'd0, bcd_q[11:8]};
      endcase
    end else begin
      mem_wdata = vregs_q[ctrl_i.step];
    end
  end

  c8ie_ram #(.Width(8), .Depth(MemDepth)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign stk_top = (depth_q == '0) ? '0 : stk_q[SW'(depth_q - DW'(1))];

  // combinational execution of everything but memory moves, committed on exec
  logic [11:0] pc_seq, pc_skip;
  logic        wr_x, wr_f, wr_i, push, pop;
  logic [7:0]  x_val, f_val;
  logic [15:0] i_val;
  logic [11:0] pc_new;
  logic [1:0]  ph_new;
  logic [3:0]  held_new;
  logic [8:0]  sum9;
  logic        key_hit;

  assign pc_seq  = 12'(pc_q + 12'd2);
  assign pc_skip = 12'(pc_q + 12'd4);
  assign sum9    = {1'b0, vx_q} + {1'b0, vy_q};
  assign key_hit = (vx_q < 8'(c8ie_pkg::KeyCount)) && item_q.keys_down[vx_q[3:0]];

  always_comb begin
    wr_x = 1'b0; wr_f = 1'b0; wr_i = 1'b0; push = 1'b0; pop = 1'b0;
    x_val = '0; f_val = '0; i_val = idx_q;
    pc_new = pc_seq; ph_new = phase_q; held_new = held_q;
    res_d = '0;
    case (item_q.opcode)
      c8ie_pkg::OP_CLS: res_d.clear_screen = 1'b1;
      c8ie_pkg::OP_RET: begin
        if (depth_q == '0) begin
          res_d.stack_fault = 1'b1; pc_new = pc_q;
        end else begin
          pop = 1'b1; pc_new = stk_top;
        end
      end
      c8ie_pkg::OP_JMP: pc_new = item_q.imm_addr;
      c8ie_pkg::OP_CALL: begin
        if (depth_q >= DW'(StackDepth)) begin
          res_d.stack_fault = 1'b1; pc_new = pc_q;
        end else begin
          push = 1'b1; pc_new = item_q.imm_addr;
        end
      end
      c8ie_pkg::OP_SEQ:  if (vx_q == item_q.imm_byte) pc_new = pc_skip;
      c8ie_pkg::OP_SNE:  if (vx_q != item_q.imm_byte) pc_new = pc_skip;
      c8ie_pkg::OP_SCEQ: if (vx_q == vy_q) pc_new = pc_skip;
      c8ie_pkg::OP_SCNE: if (vx_q != vy_q) pc_new = pc_skip;
      c8ie_pkg::OP_LD:   begin wr_x = 1'b1; x_val = item_q.imm_byte; end
      c8ie_pkg::OP_ADD:  begin wr_x = 1'b1; x_val = 8'(vx_q + item_q.imm_byte); end
      c8ie_pkg::OP_CP:   begin wr_x = 1'b1; x_val = vy_q; end
      c8ie_pkg::OP_OR:   begin wr_x = 1'b1; x_val = vx_q | vy_q; end
      c8ie_pkg::OP_AND:  begin wr_x = 1'b1; x_val = vx_q & vy_q; end
      c8ie_pkg::OP_XOR:  begin wr_x = 1'b1; x_val = vx_q ^ vy_q; end
      c8ie_pkg::OP_ADDC: begin
        wr_x = 1'b1; x_val = sum9[7:0]; wr_f = 1'b1; f_val = {7'd0, sum9[8]};
      end
      c8ie_pkg::OP_SUB: begin
        wr_x = 1'b1; x_val = 8'(vx_q - vy_q);
        wr_f = 1'b1; f_val = {7'd0, vx_q >= vy_q};
      end
      c8ie_pkg::OP_SHR: begin
        wr_x = 1'b1; x_val = {1'b0, vy_q[7:1]}; wr_f = 1'b1; f_val = {7'd0, vy_q[0]};
      end
      c8ie_pkg::OP_SUBI: begin
        wr_x = 1'b1; x_val = 8'(vy_q - vx_q);
        wr_f = 1'b1; f_val = {7'd0, vy_q >= vx_q};
      end
      c8ie_pkg::OP_SHL: begin
        wr_x = 1'b1; x_val = {vy_q[6:0], 1'b0}; wr_f = 1'b1; f_val = {7'd0, vy_q[7]};
      end
      c8ie_pkg::OP_LDI:  begin wr_i = 1'b1; i_val = {4'd0, item_q.imm_addr}; end
      c8ie_pkg::OP_JMPO: pc_new = 12'({4'd0, vregs_q[0]} + item_q.imm_addr);
      c8ie_pkg::OP_RND:  begin wr_x = 1'b1; x_val = item_q.imm_byte & item_q.random_byte; end
      c8ie_pkg::OP_SKP:  if (key_hit) pc_new = pc_skip;
      c8ie_pkg::OP_SKNP: if (!key_hit) pc_new = pc_skip;
      c8ie_pkg::OP_WKP: begin
        if (phase_q == c8ie_pkg::PH_PRESS) begin
          for (int k = 0; k < c8ie_pkg::KeyCount; k++) begin
            if (item_q.keys_down[k]) begin
              held_new = 4'(k); ph_new = c8ie_pkg::PH_RELEASE;
            end
          end
          pc_new = pc_q; res_d.key_waiting = 1'b1;
        end else if (phase_q == c8ie_pkg::PH_RELEASE) begin
          if (item_q.keys_down == '0) begin
            ph_new = c8ie_pkg::PH_IDLE; wr_x = 1'b1; x_val = {4'd0, held_q};
          end else begin
            pc_new = pc_q; res_d.key_waiting = 1'b1;
          end
        end else begin
          ph_new = c8ie_pkg::PH_PRESS; pc_new = pc_q; res_d.key_waiting = 1'b1;
        end
      end
      c8ie_pkg::OP_ADDI: begin wr_i = 1'b1; i_val = 16'(idx_q + {8'd0, vx_q}); end
      c8ie_pkg::OP_SETT: begin res_d.timer_write = 1'b1; res_d.timer_value = vx_q; end
      c8ie_pkg::OP_GETT: begin wr_x = 1'b1; x_val = item_q.timer_now; end
      default: ;
    endcase
    res_d.next_pc = pc_new;
  end

  // double dabble: 8 shift steps into three bcd digits
  logic [19:0] bcd_adj;
  assign bcd_adj = {c8ie_pkg::dd_adj(bcd_q[19:16]), c8ie_pkg::dd_adj(bcd_q[15:12]),
                    c8ie_pkg::dd_adj(bcd_q[11:8]), bcd_q[7:0]};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_item) item_q <= in_item_i;
    if (ctrl_i.exec) res_q <= res_d;
    if (ctrl_i.exec && push) stk_q[SW'(depth_q)] <= pc_seq;
    if (ctrl_i.mem_rd) rd_step_q <= ctrl_i.step;
    if (ctrl_i.bcd_start) bcd_q <= {12'd0, vx_q};
    else if (ctrl_i.bcd_shift) bcd_q <= {bcd_adj[18:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) vregs_q[i] <= '0;
      pc_q    <= c8ie_pkg::PcReset;
      idx_q   <= '0;
      depth_q <= '0;
      phase_q <= c8ie_pkg::PH_IDLE;
      held_q  <= '0;
      vx_q    <= '0;
      vy_q    <= '0;
      clr_q   <= '0;
    end else begin
      if (ctrl_i.mem_clr) clr_q <= AW'(clr_q + AW'(1));
      if (ctrl_i.load_item) begin
        vx_q <= vregs_q[in_item_i.reg_x];
        vy_q <= vregs_q[in_item_i.reg_y];
      end
      // read data belongs to the offset of the read issued in the previous cycle
      if (ctrl_i.rd_wb) vregs_q[rd_step_q] <= mem_rdata;
      if (ctrl_i.exec) begin
        pc_q    <= pc_new;
        phase_q <= ph_new;
        held_q  <= held_new;
        if (wr_i) idx_q <= i_val;
        if (push) depth_q <= DW'(depth_q + DW'(1));
        if (pop)  depth_q <= DW'(depth_q - DW'(1));
        // flag wins over the result, so vf as target keeps the flag
        if (wr_x && !(wr_f && item_q.reg_x == c8ie_pkg::FlagReg)) begin
          vregs_q[item_q.reg_x] <= x_val;
        end
        if (wr_f) vregs_q[c8ie_pkg::FlagReg] <= f_val;
      end
    end
  end
endmodule
`default_nettype wire
